>>> hw/rtl/hmbd_pkg.sv
package hmbd_pkg;

  // widths fixed by the bus and the configuration registers
  localparam int SIZE_W     = 26;
  localparam int CART_OFF_W = 25;

  // default store sizes
  localparam int LARGE_RAM_BYTES_DEF = 262144;
  localparam int SMALL_RAM_BYTES_DEF = 32768;
  localparam int VIDEO_RAM_BYTES_DEF = 98304;
  localparam int CART_ROM_BYTES_DEF  = 33554432;
  localparam int TABLE_RAM_BYTES_DEF = 1024;
  localparam int IO_SPACE_BYTES_DEF  = 1024;

  localparam int BOOT_BYTES = 16384;
  localparam int BOOT_AW    = 14;

  // mirroring masks
  localparam logic [23:0] LARGE_MASK = 24'h03FFFF;
  localparam logic [23:0] SMALL_MASK = 24'h007FFF;
  localparam logic [23:0] VIDEO_MASK = 24'h017FFF;
  localparam logic [23:0] TABLE_MASK = 24'h0003FF;

  // region codes (top address byte)
  localparam logic [7:0] TOP_LARGE = 8'h02;
  localparam logic [7:0] TOP_SMALL = 8'h03;
  localparam logic [7:0] TOP_IO    = 8'h04;
  localparam logic [7:0] TOP_PAL   = 8'h05;
  localparam logic [7:0] TOP_VID   = 8'h06;
  localparam logic [7:0] TOP_OBJ   = 8'h07;
  localparam logic [7:0] TOP_CART0 = 8'h08;
  localparam logic [7:0] TOP_CART5 = 8'h0D;

  // i/o register offsets and fifo ports
  localparam logic [SIZE_W-1:0] OFF_KEYS   = SIZE_W'(32'h130);
  localparam logic [SIZE_W-1:0] OFF_IFLAGS = SIZE_W'(32'h202);
  localparam logic [SIZE_W-1:0] OFF_IME    = SIZE_W'(32'h208);
  localparam logic [SIZE_W-1:0] OFF_SNDH   = SIZE_W'(32'h082);
  localparam logic [31:0] PORT_A = 32'h040000A0;
  localparam logic [31:0] PORT_B = 32'h040000A4;

  // request and size codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;
  localparam logic [1:0] SZ_BYTE   = 2'd0;
  localparam logic [1:0] SZ_HALF   = 2'd1;
  localparam logic [1:0] SZ_WORD   = 2'd2;

  // fifo push codes
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_A    = 2'd1;
  localparam logic [1:0] PUSH_B    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BOOT_PRESENT = 2'd0;
  localparam logic [1:0] CFG_CART_SIZE    = 2'd1;
  localparam logic [1:0] CFG_SAVE_EEPROM  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  access_size;
    logic [31:0] bus_address;
    logic [31:0] write_data;
    logic [31:0] program_counter;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  fifo_push;
    logic [31:0] fifo_word;
    logic        fifo_a_clear;
    logic        fifo_b_clear;
  } rsp_t;

  typedef enum logic [2:0] {
    S_BOOT, S_CART, S_LARGE, S_SMALL, S_PAL, S_VID, S_OBJ, S_IO
  } store_t;

  typedef enum logic [3:0] {
    K_ZERO, K_READ, K_BOOT_RD, K_LATCH, K_CART_RD, K_WRITE, K_IO_WR, K_FIFO_A, K_FIFO_B
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_RD_ADDR, ST_RD_DATA, ST_WR,
    ST_IO_RA, ST_IO_RB, ST_IO_RC, ST_IO_WA, ST_IO_WB, ST_FINISH
  } state_t;

endpackage

>>> hw/rtl/hmbd_byte_ram.sv
module hmbd_byte_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/hmbd_mod_unit.sv
module hmbd_mod_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hmbd_pkg::CART_OFF_W-1:0] dividend,
  input  logic [hmbd_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [hmbd_pkg::SIZE_W-1:0]   remainder
);
  import hmbd_pkg::*;

  localparam int CW = $clog2(CART_OFF_W);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [CART_OFF_W-1:0] dvd;
  logic [SIZE_W-1:0]     dvs;
  logic [SIZE_W-1:0]     rem;
  logic [SIZE_W:0]       trial;
  logic [SIZE_W-1:0]     rem_next;

  // one restoring step per cycle, msb first
  always_comb begin
    trial = {rem, dvd[CART_OFF_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = SIZE_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(CART_OFF_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= rem_next;
      dvd <= {dvd[CART_OFF_W-2:0], 1'b0};
    end
  end

  assign remainder = rem;

endmodule

>>> hw/rtl/handheld_memory_bus_decoder.sv
// Bus decoder for a handheld console memory map. One request beat (read, write or
// image load of byte, halfword or word) gives exactly one response beat. Every store
// sits in a single-port byte memory with registered read data, so the block walks an
// access one byte at a time: a read passes an address state and then a data state for
// each byte, a write or load writes one byte on each pass of the write state, and every
// access is accepted in the idle state and handed off from a finish state. Cartridge reads
// first run the offset through a bit-serial remainder unit against the configured ROM
// size. An i/o write is a read-modify-write of each halfword it touches (the aligned
// halfword for a byte or halfword, two halfwords for a word). After reset the i/o
// register bytes are cleared by a pass over all IO_SPACE_BYTES of them, during which
// no request is taken; the configuration port is always ready. A finished response sits
// in an output register, so the next request is taken while it waits.
module handheld_memory_bus_decoder #(
  parameter int LARGE_RAM_BYTES = hmbd_pkg::LARGE_RAM_BYTES_DEF,
  parameter int SMALL_RAM_BYTES = hmbd_pkg::SMALL_RAM_BYTES_DEF,
  parameter int VIDEO_RAM_BYTES = hmbd_pkg::VIDEO_RAM_BYTES_DEF,
  parameter int CART_ROM_BYTES  = hmbd_pkg::CART_ROM_BYTES_DEF,
  parameter int TABLE_RAM_BYTES = hmbd_pkg::TABLE_RAM_BYTES_DEF,
  parameter int IO_SPACE_BYTES  = hmbd_pkg::IO_SPACE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [hmbd_pkg::SIZE_W-1:0] cfg_data,
  // request channel
  input  logic                        req_valid,
  output logic                        req_stall,
  input  hmbd_pkg::req_t              req,
  // response channel
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output hmbd_pkg::rsp_t              rsp
);
  import hmbd_pkg::*;

  localparam int CART_AW  = $clog2(CART_ROM_BYTES);
  localparam int LARGE_AW = $clog2(LARGE_RAM_BYTES);
  localparam int SMALL_AW = $clog2(SMALL_RAM_BYTES);
  localparam int VIDEO_AW = $clog2(VIDEO_RAM_BYTES);
  localparam int TABLE_AW = $clog2(TABLE_RAM_BYTES);
  localparam int IO_AW    = $clog2(IO_SPACE_BYTES);

  // configuration registers
  logic              boot_present;
  logic [SIZE_W-1:0] cart_size;
  logic              save_eeprom;
  logic [SIZE_W-1:0] sz_sat;

  // control
  state_t          state, state_next;
  logic            accept;
  logic            rsp_load;
  logic [IO_AW-1:0] clr_cnt;

  // per-item registers
  kind_t             kind;
  store_t            sel;
  logic [SIZE_W-1:0] ptr;
  logic [1:0]        cnt_last;
  logic [1:0]        idx;
  logic [31:0]       acc;
  logic [31:0]       wbuf;
  logic [31:0]       wd;
  logic [1:0]        size;
  logic [1:0]        a_lo;
  logic              put_k;
  logic [7:0]        old_lo;
  logic [15:0]       hv;
  logic              ca, cb;
  logic [SIZE_W-1:0] cart_sz;
  logic [31:0]       open_bus_latch;

  // decode of the incoming beat
  kind_t             dec_kind;
  store_t            dec_sel;
  logic [SIZE_W-1:0] dec_ptr;
  logic [1:0]        dec_cnt;
  logic [31:0]       dec_wbuf;
  logic [7:0]        top;
  logic [23:0]       low;
  logic [SIZE_W-1:0] n_ext;
  logic              r_hit;
  store_t            r_sel;
  logic [23:0]       r_mask;
  logic [SIZE_W-1:0] r_lim;
  logic [SIZE_W-1:0] r_off;
  logic [SIZE_W-1:0] r_off_al;
  logic [SIZE_W-1:0] io_off;

  // memory port
  store_t            mem_sel;
  logic [SIZE_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;
  logic [SIZE_W-1:0] sel_lim;
  logic [7:0]        rd_boot, rd_cart, rd_large, rd_small, rd_pal, rd_vid, rd_obj, rd_io;

  // remainder unit
  logic              mod_start;
  logic              mod_done;
  logic [SIZE_W-1:0] mod_rem;

  // i/o halfword update
  logic [15:0] io_old, io_src, io_v;
  logic        io_ca, io_cb;

  // result assembly
  rsp_t        rsp_next;
  logic [31:0] fm;
  logic [4:0]  sh;
  logic [31:0] latch_next;
  logic        two_puts;

  //--------------------------------------------------------------------------
  // configuration port, always ready
  //--------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_present <= 1'b0;
      cart_size    <= '0;
      save_eeprom  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BOOT_PRESENT: boot_present <= cfg_data[0];
        CFG_CART_SIZE:    cart_size    <= cfg_data;
        CFG_SAVE_EEPROM:  save_eeprom  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // rom size saturates at the store depth
  assign sz_sat = (cart_size > SIZE_W'(CART_ROM_BYTES)) ? SIZE_W'(CART_ROM_BYTES) : cart_size;

  //--------------------------------------------------------------------------
  // request decode
  //--------------------------------------------------------------------------
  assign top   = req.bus_address[31:24];
  assign low   = req.bus_address[23:0];
  assign n_ext = (req.access_size == SZ_WORD) ? SIZE_W'(4) :
                 (req.access_size == SZ_HALF) ? SIZE_W'(2) : SIZE_W'(1);
  assign io_off = SIZE_W'(low);

  // mirrored ram regions
  always_comb begin
    r_hit  = 1'b1;
    r_sel  = S_LARGE;
    r_mask = LARGE_MASK;
    r_lim  = SIZE_W'(LARGE_RAM_BYTES);
    case (top)
      TOP_LARGE: begin
        r_sel = S_LARGE; r_mask = LARGE_MASK; r_lim = SIZE_W'(LARGE_RAM_BYTES);
      end
      TOP_SMALL: begin
        r_sel = S_SMALL; r_mask = SMALL_MASK; r_lim = SIZE_W'(SMALL_RAM_BYTES);
      end
      TOP_PAL: begin
        r_sel = S_PAL; r_mask = TABLE_MASK; r_lim = SIZE_W'(TABLE_RAM_BYTES);
      end
      TOP_VID: begin
        r_sel = S_VID; r_mask = VIDEO_MASK; r_lim = SIZE_W'(VIDEO_RAM_BYTES);
      end
      TOP_OBJ: begin
        r_sel = S_OBJ; r_mask = TABLE_MASK; r_lim = SIZE_W'(TABLE_RAM_BYTES);
      end
      default: r_hit = 1'b0;
    endcase
    r_off    = SIZE_W'(low & r_mask);
    r_off_al = SIZE_W'({low[23:1], 1'b0} & r_mask);
  end

  always_comb begin
    dec_kind = K_ZERO;
    dec_sel  = S_BOOT;
    dec_ptr  = '0;
    dec_cnt  = (req.access_size == SZ_WORD) ? 2'd3 :
               (req.access_size == SZ_HALF) ? 2'd1 : 2'd0;
    dec_wbuf = req.write_data;
    if (req.req_type == REQ_READ && req.access_size != 2'd3) begin
      if (boot_present && req.bus_address[31:BOOT_AW] == '0) begin
        // boot rom readable only while fetching from it
        if (req.program_counter[31:BOOT_AW] == '0 &&
            SIZE_W'(req.bus_address[BOOT_AW-1:0]) + n_ext <= SIZE_W'(BOOT_BYTES)) begin
          dec_kind = K_BOOT_RD;
          dec_ptr  = SIZE_W'(req.bus_address[BOOT_AW-1:0]);
        end else begin
          dec_kind = K_LATCH;
        end
      end else if (r_hit) begin
        if (r_off + n_ext <= r_lim) begin
          dec_kind = K_READ;
          dec_sel  = r_sel;
          dec_ptr  = r_off;
        end
      end else if (top == TOP_IO) begin
        if (io_off + n_ext <= SIZE_W'(IO_SPACE_BYTES)) begin
          dec_kind = K_READ;
          dec_sel  = S_IO;
          dec_ptr  = (req.access_size == SZ_HALF) ? {io_off[SIZE_W-1:1], 1'b0} : io_off;
        end
      end else if (top inside {[TOP_CART0:TOP_CART5]}) begin
        if (!(save_eeprom && top == TOP_CART5) && sz_sat != '0) begin
          dec_kind = K_CART_RD;
          dec_sel  = S_CART;
        end
      end
    end else if (req.req_type == REQ_WRITE && req.access_size != 2'd3) begin
      if (req.access_size == SZ_WORD && req.bus_address == PORT_A) begin
        dec_kind = K_FIFO_A;
      end else if (req.access_size == SZ_WORD && req.bus_address == PORT_B) begin
        dec_kind = K_FIFO_B;
      end else if (r_hit) begin
        if (req.access_size == SZ_BYTE && top >= TOP_PAL) begin
          // video stores take a byte into both halves of the halfword
          if (r_off_al + SIZE_W'(1) < r_lim) begin
            dec_kind = K_WRITE;
            dec_sel  = r_sel;
            dec_ptr  = r_off_al;
            dec_cnt  = 2'd1;
            dec_wbuf = {16'h0000, req.write_data[7:0], req.write_data[7:0]};
          end
        end else if (r_off + n_ext <= r_lim) begin
          dec_kind = K_WRITE;
          dec_sel  = r_sel;
          dec_ptr  = r_off;
        end
      end else if (top == TOP_IO) begin
        if (io_off + n_ext <= SIZE_W'(IO_SPACE_BYTES)) begin
          dec_kind = K_IO_WR;
          dec_sel  = S_IO;
          dec_ptr  = (req.access_size == SZ_WORD) ? io_off : {io_off[SIZE_W-1:1], 1'b0};
        end
      end
    end else if (req.req_type == REQ_LOAD && req.access_size != 2'd3) begin
      // raw image fill, bytes past the store are dropped one by one
      if (req.bus_address[31:BOOT_AW] == '0) begin
        dec_kind = K_WRITE;
        dec_sel  = S_BOOT;
        dec_ptr  = SIZE_W'(req.bus_address[BOOT_AW-1:0]);
      end else if (top == TOP_IO) begin
        dec_kind = K_WRITE;
        dec_sel  = S_IO;
        dec_ptr  = io_off;
      end else if (top inside {[TOP_CART0:TOP_CART5]}) begin
        dec_kind = K_WRITE;
        dec_sel  = S_CART;
        dec_ptr  = SIZE_W'(req.bus_address[CART_OFF_W-1:0]);
      end
    end
  end

  //--------------------------------------------------------------------------
  // sequencer
  //--------------------------------------------------------------------------
  assign accept   = req_valid && state == ST_IDLE;
  assign rsp_load = state == ST_FINISH && (!rsp_valid || !rsp_stall);
  assign two_puts = size == SZ_WORD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == IO_AW'(IO_SPACE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          case (dec_kind)
            K_READ, K_BOOT_RD: state_next = ST_RD_ADDR;
            K_CART_RD:         state_next = ST_MOD;
            K_WRITE:           state_next = ST_WR;
            K_IO_WR:           state_next = ST_IO_RA;
            default:           state_next = ST_FINISH;
          endcase
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_RD_ADDR;
        end
      end
      ST_RD_ADDR: state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = (idx == cnt_last) ? ST_FINISH : ST_RD_ADDR;
      ST_WR:      state_next = (idx == cnt_last) ? ST_FINISH : ST_WR;
      ST_IO_RA:   state_next = ST_IO_RB;
      ST_IO_RB:   state_next = ST_IO_RC;
      ST_IO_RC:   state_next = ST_IO_WA;
      ST_IO_WA:   state_next = ST_IO_WB;
      ST_IO_WB:   state_next = (two_puts && !put_k) ? ST_IO_RA : ST_FINISH;
      ST_FINISH: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // limit of the selected store, gates the byte writes of ST_WR
  always_comb begin
    case (sel)
      S_BOOT:  sel_lim = SIZE_W'(BOOT_BYTES);
      S_CART:  sel_lim = SIZE_W'(CART_ROM_BYTES);
      S_LARGE: sel_lim = SIZE_W'(LARGE_RAM_BYTES);
      S_SMALL: sel_lim = SIZE_W'(SMALL_RAM_BYTES);
      S_PAL:   sel_lim = SIZE_W'(TABLE_RAM_BYTES);
      S_VID:   sel_lim = SIZE_W'(VIDEO_RAM_BYTES);
      S_OBJ:   sel_lim = SIZE_W'(TABLE_RAM_BYTES);
      S_IO:    sel_lim = SIZE_W'(IO_SPACE_BYTES);
      default: sel_lim = '0;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    req_stall = state != ST_IDLE;
    mod_start = accept && dec_kind == K_CART_RD;
    mem_sel   = sel;
    mem_addr  = ptr;
    mem_we    = 1'b0;
    mem_wdata = wbuf[7:0];
    case (state)
      ST_CLEAR: begin
        mem_sel   = S_IO;
        mem_addr  = SIZE_W'(clr_cnt);
        mem_we    = 1'b1;
        mem_wdata = 8'h00;
      end
      ST_WR: begin
        mem_we = ptr < sel_lim;
      end
      ST_IO_RB: begin
        mem_addr = ptr + SIZE_W'(1);
      end
      ST_IO_WA: begin
        // key register ignores bus writes
        mem_we    = ptr != OFF_KEYS;
        mem_wdata = hv[7:0];
      end
      ST_IO_WB: begin
        mem_addr  = ptr + SIZE_W'(1);
        mem_we    = ptr != OFF_KEYS;
        mem_wdata = hv[15:8];
      end
      default: ;
    endcase
  end

  // i/o halfword rules, old high byte arrives from memory in ST_IO_RC
  always_comb begin
    io_old = {mem_rdata, old_lo};
    case (size)
      SZ_WORD: io_src = put_k ? wd[31:16] : wd[15:0];
      SZ_HALF: io_src = wd[15:0];
      default: io_src = a_lo[0] ? {wd[7:0], io_old[7:0]} : {io_old[15:8], wd[7:0]};
    endcase
    io_v  = io_src;
    io_ca = 1'b0;
    io_cb = 1'b0;
    if (ptr == OFF_IFLAGS) begin
      io_v = io_old & ~io_src;
    end
    if (ptr == OFF_IME) begin
      io_v = {15'h0000, io_src[0]};
    end
    if (ptr == OFF_SNDH) begin
      io_ca    = io_src[11];
      io_cb    = io_src[15];
      io_v[11] = 1'b0;
      io_v[15] = 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind     <= dec_kind;
      sel      <= dec_sel;
      ptr      <= dec_ptr;
      cnt_last <= dec_cnt;
      wbuf     <= dec_wbuf;
      wd       <= req.write_data;
      size     <= req.access_size;
      a_lo     <= req.bus_address[1:0];
      idx      <= '0;
      acc      <= '0;
      put_k    <= 1'b0;
      ca       <= 1'b0;
      cb       <= 1'b0;
      cart_sz  <= sz_sat;
    end
    case (state)
      ST_MOD: begin
        if (mod_done) begin
          ptr <= mod_rem;
        end
      end
      ST_RD_DATA: begin
        acc[{idx, 3'b000} +: 8] <= mem_rdata;
        idx <= idx + 1'b1;
        // cartridge reads wrap at the rom size
        if (kind == K_CART_RD && ptr + SIZE_W'(1) == cart_sz) begin
          ptr <= '0;
        end else begin
          ptr <= ptr + SIZE_W'(1);
        end
      end
      ST_WR: begin
        wbuf <= {8'h00, wbuf[31:8]};
        idx  <= idx + 1'b1;
        ptr  <= ptr + SIZE_W'(1);
      end
      ST_IO_RB: old_lo <= mem_rdata;
      ST_IO_RC: begin
        hv <= io_v;
        ca <= ca | io_ca;
        cb <= cb | io_cb;
      end
      ST_IO_WB: begin
        ptr   <= ptr + SIZE_W'(2);
        put_k <= 1'b1;
      end
      default: ;
    endcase
  end

  //--------------------------------------------------------------------------
  // open-bus latch and response
  //--------------------------------------------------------------------------
  always_comb begin
    fm = (size == SZ_WORD) ? 32'hFFFF_FFFF : (size == SZ_HALF) ? 32'h0000_FFFF : 32'h0000_00FF;
    sh = (size == SZ_HALF) ? {a_lo[1], 4'b0000} : {a_lo, 3'b000};
    if (size == SZ_WORD) begin
      latch_next = acc;
    end else begin
      latch_next = (open_bus_latch & ~(fm << sh)) | (acc << sh);
    end

    rsp_next = '0;
    case (kind)
      K_READ, K_CART_RD, K_BOOT_RD: rsp_next.read_data = acc;
      K_LATCH: begin
        rsp_next.read_data = (size == SZ_WORD) ? open_bus_latch : (open_bus_latch >> sh) & fm;
      end
      K_IO_WR: begin
        rsp_next.fifo_a_clear = ca;
        rsp_next.fifo_b_clear = cb;
      end
      K_FIFO_A: begin
        rsp_next.fifo_push = PUSH_A;
        rsp_next.fifo_word = wd;
      end
      K_FIFO_B: begin
        rsp_next.fifo_push = PUSH_B;
        rsp_next.fifo_word = wd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_bus_latch <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        if (kind == K_BOOT_RD) begin
          open_bus_latch <= latch_next;
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  //--------------------------------------------------------------------------
  // stores
  //--------------------------------------------------------------------------
  hmbd_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (req.bus_address[CART_OFF_W-1:0]),
    .divisor   (sz_sat),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  hmbd_byte_ram #(.DEPTH(BOOT_BYTES), .AW(BOOT_AW)) u_boot (
    .clk(clk), .we(mem_we && mem_sel == S_BOOT), .addr(mem_addr[BOOT_AW-1:0]),
    .wdata(mem_wdata), .rdata(rd_boot)
  );

  hmbd_byte_ram #(.DEPTH(CART_ROM_BYTES), .AW(CART_AW)) u_cart (
    .clk(clk), .we(mem_we && mem_sel == S_CART), .addr(mem_addr[CART_AW-1:0]),
    .wdata(mem_wdata), .rdata(rd_cart)
  );

  hmbd_byte_ram #(.DEPTH(LARGE_RAM_BYTES), .AW(LARGE_AW)) u_large (
    .clk(clk), .we(mem_we && mem_sel == S_LARGE), .addr(mem_addr[LARGE_AW-1:0]),
    .wdata(mem_wdata), .rdata(rd_large)
  );

  hmbd_byte_ram #(.DEPTH(SMALL_RAM_BYTES), .AW(SMALL_AW)) u_small (
    .clk(clk), .we(mem_we && mem_sel == S_SMALL), .addr(mem_addr[SMALL_AW-1:0]),
    .wdata(mem_wdata), .rdata(rd_small)
  );

  hmbd_byte_ram #(.DEPTH(TABLE_RAM_BYTES), .AW(TABLE_AW)) u_pal (
    .clk(clk), .we(mem_we && mem_sel == S_PAL), .addr(mem_addr[TABLE_AW-1:0]),
    .wdata(mem_wdata), .rdata(rd_pal)
  );

  hmbd_byte_ram #(.DEPTH(VIDEO_RAM_BYTES), .AW(VIDEO_AW)) u_vid (
    .clk(clk), .we(mem_we && mem_sel == S_VID), .addr(mem_addr[VIDEO_AW-1:0]),
    .wdata(mem_wdata), .rdata(rd_vid)
  );

  hmbd_byte_ram #(.DEPTH(TABLE_RAM_BYTES), .AW(TABLE_AW)) u_obj (
    .clk(clk), .we(mem_we && mem_sel == S_OBJ), .addr(mem_addr[TABLE_AW-1:0]),
    .wdata(mem_wdata), .rdata(rd_obj)
  );

  hmbd_byte_ram #(.DEPTH(IO_SPACE_BYTES), .AW(IO_AW)) u_io (
    .clk(clk), .we(mem_we && mem_sel == S_IO), .addr(mem_addr[IO_AW-1:0]),
    .wdata(mem_wdata), .rdata(rd_io)
  );

  // sel holds across the read cycle, so it steers the returning byte
  always_comb begin
    case (sel)
      S_BOOT:  mem_rdata = rd_boot;
      S_CART:  mem_rdata = rd_cart;
      S_LARGE: mem_rdata = rd_large;
      S_SMALL: mem_rdata = rd_small;
      S_PAL:   mem_rdata = rd_pal;
      S_VID:   mem_rdata = rd_vid;
      S_OBJ:   mem_rdata = rd_obj;
      S_IO:    mem_rdata = rd_io;
      default: mem_rdata = 8'h00;
    endcase
  end

  //--------------------------------------------------------------------------
  // checks
  //--------------------------------------------------------------------------
  a_mod_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == ST_MOD)
    else $error("remainder finished outside cartridge read");

  a_no_rsp_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !rsp_valid)
    else $error("response during clearing pass");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE && state != ST_CLEAR)
    else $error("accepted beat dropped");

  a_fifo_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.fifo_push == PUSH_NONE |-> rsp.fifo_word == '0)
    else $error("fifo word without push");

  a_push_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.fifo_push != PUSH_NONE |->
      rsp.read_data == '0 && !rsp.fifo_a_clear && !rsp.fifo_b_clear)
    else $error("push mixed with other results");

endmodule

>>> dv/handheld_memory_bus_decoder_test.sv
module handheld_memory_bus_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hmbd_pkg::*;

  // bus map constants used by the shadow decoder
  localparam bit [31:0] BOOT_LIMIT = 32'h0000_4000;
  localparam bit [31:0] IO_BASE    = 32'h0400_0000;
  localparam bit [31:0] CART_BASE  = 32'h0800_0000;
  localparam bit [31:0] CART_MASK  = 32'h01FF_FFFF;
  localparam bit [7:0]  TOP_SAVE   = 8'h0E;

  typedef struct {
    bit [31:0] addr;
    bit [1:0]  size;
  } touch_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [SIZE_W-1:0]   cfg_data = '0;
  logic                req_valid = 1'b0;
  logic                req_stall;
  req_t                req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  rsp_t                rsp;

  // shadow copy of the decoder state
  bit                  boot_on;
  bit [25:0]           cart_cfg;
  bit                  eeprom_on;
  bit [31:0]           bus_latch;
  bit [7:0]            io_bytes [IO_SPACE_BYTES_DEF];
  bit [7:0]            store_bytes [longint unsigned];

  touch_t              touched [$];
  req_t                pending_reqs [$];
  rsp_t                expected_rsps [$];
  rsp_t                want;
  int                  errors = 0;
  int                  sent = 0;
  int                  hold_left = 0;
  bit                  hold_done = 1'b0;
  wire                 calm = (sent >= 450) && (sent < 560);

  handheld_memory_bus_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- shadow decoder

  function automatic longint unsigned skey(store_t s, int unsigned off);
    return (longint'(s) << 32) | longint'(off);
  endfunction

  function automatic bit [7:0] byte_at(store_t s, int unsigned off);
    longint unsigned k;
    k = skey(s, off);
    return store_bytes.exists(k) ? store_bytes[k] : 8'h00;
  endfunction

  function automatic bit ram_map(bit [31:0] a, output store_t s, output int unsigned off,
                                 output int unsigned lim);
    s = S_BOOT;
    off = 0;
    lim = 0;
    case (a[31:24])
      TOP_LARGE: begin s = S_LARGE; off = a[23:0] & LARGE_MASK; lim = LARGE_RAM_BYTES_DEF; end
      TOP_SMALL: begin s = S_SMALL; off = a[23:0] & SMALL_MASK; lim = SMALL_RAM_BYTES_DEF; end
      TOP_PAL:   begin s = S_PAL;   off = a[23:0] & TABLE_MASK; lim = TABLE_RAM_BYTES_DEF; end
      TOP_VID:   begin s = S_VID;   off = a[23:0] & VIDEO_MASK; lim = VIDEO_RAM_BYTES_DEF; end
      TOP_OBJ:   begin s = S_OBJ;   off = a[23:0] & TABLE_MASK; lim = TABLE_RAM_BYTES_DEF; end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit [15:0] io_half(int unsigned o);
    if (o + 1 >= IO_SPACE_BYTES_DEF) return 16'h0;
    return {io_bytes[o + 1], io_bytes[o]};
  endfunction

  // one halfword register write with the side-effect rules
  function automatic void io_put(int unsigned o, bit [15:0] v, inout bit ca, inout bit cb);
    if (o + 1 >= IO_SPACE_BYTES_DEF) return;
    if (o == OFF_KEYS) return;
    if (o == OFF_IFLAGS) v = io_half(o) & ~v;
    if (o == OFF_IME) v &= 16'h0001;
    if (o == OFF_SNDH) begin
      if (v[11]) begin ca = 1'b1; v[11] = 1'b0; end
      if (v[15]) begin cb = 1'b1; v[15] = 1'b0; end
    end
    io_bytes[o] = v[7:0];
    io_bytes[o + 1] = v[15:8];
  endfunction

  function automatic int unsigned beat_bytes(bit [1:0] size);
    return size == SZ_BYTE ? 1 : (size == SZ_HALF ? 2 : 4);
  endfunction

  function automatic int unsigned cart_bytes();
    return cart_cfg > CART_ROM_BYTES_DEF ? CART_ROM_BYTES_DEF : cart_cfg;
  endfunction

  // true when a read touches no store byte that was never written
  function automatic bit read_safe(req_t r);
    int unsigned n, off, lim, sz, base;
    store_t s;
    bit [31:0] a;
    a = r.bus_address;
    n = beat_bytes(r.access_size);
    if (r.req_type != REQ_READ || r.access_size == 2'd3) return 1'b1;
    if (boot_on && a < BOOT_LIMIT) begin
      off = a[13:0];
      if (r.program_counter < BOOT_LIMIT && off + n <= BOOT_BYTES)
        for (int i = 0; i < n; i++)
          if (!store_bytes.exists(skey(S_BOOT, off + i))) return 1'b0;
      return 1'b1;
    end
    if (ram_map(a, s, off, lim)) begin
      if (off + n <= lim)
        for (int i = 0; i < n; i++)
          if (!store_bytes.exists(skey(s, off + i))) return 1'b0;
      return 1'b1;
    end
    if (a[31:24] >= TOP_CART0 && a[31:24] <= TOP_CART5) begin
      sz = cart_bytes();
      if ((eeprom_on && a[31:24] == TOP_CART5) || sz == 0) return 1'b1;
      base = (a - CART_BASE) & CART_MASK;
      for (int i = 0; i < n; i++)
        if (!store_bytes.exists(skey(S_CART, (base + i) % sz))) return 1'b0;
    end
    return 1'b1;
  endfunction

  // expected response of one request; updates the shadow state
  function automatic rsp_t bus_result(req_t r);
    rsp_t e;
    int unsigned n, off, lim, sz, base, sh;
    bit [31:0] a, d, v, fm;
    bit [7:0] top;
    bit [15:0] old;
    bit ca, cb;
    store_t s;
    e = '0;
    a = r.bus_address;
    d = r.write_data;
    top = a[31:24];
    n = beat_bytes(r.access_size);
    v = '0;
    ca = 1'b0;
    cb = 1'b0;
    if (r.access_size == 2'd3 || r.req_type == 2'd3) return e;
    if (r.req_type == REQ_READ) begin
      if (boot_on && a < BOOT_LIMIT) begin
        sh = (n == 2 ? (a & 2) : (a & 3)) * 8;
        fm = n == 4 ? 32'hFFFF_FFFF : (n == 2 ? 32'h0000_FFFF : 32'h0000_00FF);
        off = a[13:0];
        if (r.program_counter < BOOT_LIMIT && off + n <= BOOT_BYTES) begin
          for (int i = 0; i < n; i++) v |= 32'(byte_at(S_BOOT, off + i)) << (8 * i);
          if (n == 4) bus_latch = v;
          else bus_latch = (bus_latch & ~(fm << sh)) | (v << sh);
          e.read_data = v;
        end else begin
          e.read_data = n == 4 ? bus_latch : (bus_latch >> sh) & fm;
        end
      end else if (ram_map(a, s, off, lim)) begin
        if (off + n <= lim)
          for (int i = 0; i < n; i++) v |= 32'(byte_at(s, off + i)) << (8 * i);
        e.read_data = v;
      end else if (top == TOP_IO) begin
        off = a - IO_BASE;
        if (off + n <= IO_SPACE_BYTES_DEF) begin
          if (n == 4) begin
            v = {io_half(off + 2), io_half(off)};
          end else begin
            v = io_half(off & ~1);
            if (n == 1) v = a[0] ? v[15:8] : v[7:0];
          end
        end
        e.read_data = v;
      end else if (top >= TOP_CART0 && top <= TOP_CART5) begin
        sz = cart_bytes();
        if (!(eeprom_on && top == TOP_CART5) && sz != 0) begin
          base = (a - CART_BASE) & CART_MASK;
          for (int i = 0; i < n; i++)
            v |= 32'(byte_at(S_CART, (base + i) % sz)) << (8 * i);
        end
        e.read_data = v;
      end
    end else if (r.req_type == REQ_WRITE) begin
      if (n == 4 && (a == PORT_A || a == PORT_B)) begin
        e.fifo_push = a == PORT_A ? PUSH_A : PUSH_B;
        e.fifo_word = d;
      end else if (ram_map(a, s, off, lim)) begin
        if (n == 1 && top >= TOP_PAL) begin
          // byte store to a video store lands in both halves
          void'(ram_map(a & ~32'h1, s, off, lim));
          if (off + 1 < lim) begin
            store_bytes[skey(s, off)] = d[7:0];
            store_bytes[skey(s, off + 1)] = d[7:0];
          end
        end else if (off + n <= lim) begin
          for (int i = 0; i < n; i++) store_bytes[skey(s, off + i)] = d[8*i +: 8];
        end
      end else if (top == TOP_IO) begin
        off = a - IO_BASE;
        if (off + n <= IO_SPACE_BYTES_DEF) begin
          if (n == 4) begin
            io_put(off, d[15:0], ca, cb);
            io_put(off + 2, d[31:16], ca, cb);
          end else if (n == 2) begin
            io_put(off & ~1, d[15:0], ca, cb);
          end else begin
            old = io_half(off & ~1);
            io_put(off & ~1, a[0] ? {d[7:0], old[7:0]} : {old[15:8], d[7:0]}, ca, cb);
          end
          e.fifo_a_clear = ca;
          e.fifo_b_clear = cb;
        end
      end
    end else begin
      // raw image load, rules bypassed
      if (a < BOOT_LIMIT) begin
        for (int i = 0; i < n; i++)
          if (a + i < BOOT_BYTES) store_bytes[skey(S_BOOT, a + i)] = d[8*i +: 8];
      end else if (top == TOP_IO) begin
        off = a - IO_BASE;
        for (int i = 0; i < n; i++)
          if (off + i < IO_SPACE_BYTES_DEF) io_bytes[off + i] = d[8*i +: 8];
      end else if (top >= TOP_CART0 && top <= TOP_CART5) begin
        off = (a - CART_BASE) & CART_MASK;
        for (int i = 0; i < n; i++)
          if (off + i < CART_ROM_BYTES_DEF) store_bytes[skey(S_CART, off + i)] = d[8*i +: 8];
      end
    end
    return e;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // queue one request and its expected response; unsafe reads become writes
  task automatic issue(req_t r);
    if (!read_safe(r)) r.req_type = REQ_WRITE;
    expected_rsps.push_back(bus_result(r));
    pending_reqs.push_back(r);
    if ((r.req_type == REQ_WRITE || r.req_type == REQ_LOAD) && r.access_size != 2'd3) begin
      touched.push_back('{r.bus_address, r.access_size});
      if (touched.size() > 512) void'(touched.pop_front());
    end
  endtask

  function automatic req_t beat_of(bit [1:0] kind, bit [1:0] size, bit [31:0] a,
                                   bit [31:0] d, bit [31:0] pc);
    req_t r;
    r.req_type = kind;
    r.access_size = size;
    r.bus_address = a;
    r.write_data = d;
    r.program_counter = pc;
    return r;
  endfunction

  function automatic bit [31:0] random_addr();
    bit [7:0] top;
    bit [23:0] low;
    case ($urandom_range(12))
      0:  return $urandom_range(0, 16383);
      1:  top = 8'h01;
      2:  top = TOP_LARGE;
      3:  top = TOP_SMALL;
      4:  top = TOP_IO;
      5:  top = TOP_PAL;
      6:  top = TOP_VID;
      7:  top = TOP_OBJ;
      8:  top = 8'($urandom_range(TOP_CART0, TOP_CART5));
      9:  top = TOP_SAVE;
      10: top = 8'hFF;
      default: top = 8'($urandom);
    endcase
    low = $urandom_range(1) ? 24'($urandom_range(0, 2047)) : 24'($urandom);
    return {top, low};
  endfunction

  // randomise address bits above a store's mirroring mask
  function automatic bit [31:0] mirror(bit [31:0] a);
    bit [23:0] m;
    case (a[31:24])
      TOP_LARGE: m = LARGE_MASK;
      TOP_SMALL: m = SMALL_MASK;
      TOP_PAL, TOP_OBJ: m = TABLE_MASK;
      TOP_VID: m = VIDEO_MASK;
      default: return a;
    endcase
    a[23:0] = (a[23:0] & m) | (24'($urandom) & ~m);
    return a;
  endfunction

  function automatic bit [31:0] random_pc();
    return $urandom_range(1) ? $urandom_range(0, 16383) : $urandom;
  endfunction

  task automatic random_item();
    int k;
    bit [31:0] a;
    bit [1:0] size;
    touch_t t;
    k = $urandom_range(99);
    size = 2'($urandom_range(2));
    if (k < 28) begin
      issue(beat_of(REQ_WRITE, size, random_addr(), $urandom, random_pc()));
    end else if (k < 38) begin
      case ($urandom_range(2))
        0: a = $urandom_range(0, 16383);
        1: a = IO_BASE + $urandom_range(0, 1100);
        default: a = {8'($urandom_range(TOP_CART0, TOP_CART5)),
                      $urandom_range(1) ? 24'($urandom_range(0, 4095)) : 24'($urandom)};
      endcase
      issue(beat_of(REQ_LOAD, size, a, $urandom, random_pc()));
    end else if (k < 75 && touched.size() > 0) begin
      t = touched[$urandom_range(touched.size() - 1)];
      a = $urandom_range(1) ? mirror(t.addr) : t.addr;
      if ($urandom_range(3) != 0) size = t.size;
      issue(beat_of(REQ_READ, size, a, $urandom,
                    $urandom_range(3) != 0 ? $urandom_range(0, 16383) : $urandom));
    end else if (k < 87) begin
      case ($urandom_range(8))
        0: a = IO_BASE + OFF_KEYS;
        1: a = IO_BASE + OFF_IFLAGS;
        2: a = IO_BASE + OFF_IME;
        3: a = IO_BASE + OFF_SNDH;
        4: a = IO_BASE + OFF_SNDH + 1;
        5: a = PORT_A;
        6: a = PORT_B;
        7: a = IO_BASE + IO_SPACE_BYTES_DEF - 2;
        default: a = IO_BASE + $urandom_range(0, 1023);
      endcase
      issue(beat_of($urandom_range(1) ? REQ_WRITE : REQ_READ, size, a, $urandom, random_pc()));
    end else begin
      issue(beat_of(2'($urandom), 2'($urandom), $urandom, $urandom, $urandom));
    end
  endtask

  task automatic write_cfg(bit [1:0] idx, bit [SIZE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BOOT_PRESENT: boot_on = value[0];
      CFG_CART_SIZE:    cart_cfg = value;
      default:          eeprom_on = value[0];
    endcase
  endtask

  // wait for every outstanding response, then let the pipeline settle
  task automatic drain();
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup_phase(bit boot, bit [SIZE_W-1:0] csize, bit eep);
    drain();
    write_cfg(CFG_BOOT_PRESENT, SIZE_W'(boot));
    write_cfg(CFG_CART_SIZE, csize);
    write_cfg(CFG_SAVE_EEPROM, SIZE_W'(eep));
    // small cartridges get filled completely so wrapped reads are defined
    if (csize != 0 && csize <= 128)
      for (int i = 0; i < csize; i += 4)
        issue(beat_of(REQ_LOAD, SZ_WORD, CART_BASE + i, $urandom, 32'h0));
  endtask

  task automatic directed_items();
    issue(beat_of(REQ_WRITE, SZ_WORD, 32'h0200_0000, 32'hDEAD_BEEF, 32'h0));
    issue(beat_of(REQ_READ,  SZ_WORD, 32'h02FC_0000, 32'h0, 32'h0));         // mirror
    issue(beat_of(REQ_READ,  SZ_WORD, 32'h0300_7FFE, 32'h0, 32'h0));         // past end
    issue(beat_of(REQ_WRITE, SZ_BYTE, 32'h0500_0001, 32'hFFFF_FFA5, 32'h0)); // dup byte
    issue(beat_of(REQ_READ,  SZ_HALF, 32'h0500_0000, 32'h0, 32'h0));
    issue(beat_of(REQ_WRITE, SZ_BYTE, 32'h0601_FFFE, 32'h0000_003C, 32'h0));
    issue(beat_of(REQ_READ,  SZ_HALF, 32'h0601_7FFE, 32'h0, 32'h0));
    issue(beat_of(REQ_WRITE, SZ_HALF, IO_BASE + OFF_KEYS, 32'hFFFF, 32'h0)); // read-only
    issue(beat_of(REQ_LOAD,  SZ_HALF, IO_BASE + OFF_IFLAGS, 32'hFFFF, 32'h0));
    issue(beat_of(REQ_WRITE, SZ_HALF, IO_BASE + OFF_IFLAGS, 32'h00F0, 32'h0));
    issue(beat_of(REQ_WRITE, SZ_WORD, IO_BASE + OFF_IME, 32'hFFFF_FFFF, 32'h0));
    issue(beat_of(REQ_READ,  SZ_WORD, IO_BASE + OFF_IME, 32'h0, 32'h0));
    issue(beat_of(REQ_WRITE, SZ_HALF, IO_BASE + OFF_SNDH, 32'h8800, 32'h0));  // fifo resets
    issue(beat_of(REQ_WRITE, SZ_BYTE, IO_BASE + OFF_SNDH + 1, 32'h88, 32'h0));
    issue(beat_of(REQ_WRITE, SZ_WORD, PORT_A, 32'h1234_5678, 32'h0));
    issue(beat_of(REQ_WRITE, SZ_WORD, PORT_B, 32'hFFFF_FFFF, 32'h0));
    issue(beat_of(REQ_WRITE, SZ_HALF, PORT_A, 32'hABCD, 32'h0));             // narrow: plain i/o
    issue(beat_of(REQ_READ,  SZ_WORD, IO_BASE + IO_SPACE_BYTES_DEF, 32'h0, 32'h0));
    issue(beat_of(REQ_LOAD,  SZ_WORD, 32'h0000_3FFC, 32'h8765_4321, 32'h0));
    issue(beat_of(REQ_READ,  SZ_WORD, 32'h0000_3FFC, 32'h0, 32'h0000_0100));  // boot inside
    issue(beat_of(REQ_READ,  SZ_HALF, 32'h0000_3FFF, 32'h0, 32'h0000_0100));  // latch
    issue(beat_of(REQ_READ,  SZ_BYTE, 32'h0000_3FFD, 32'h0, 32'hFFFF_FFFF));  // pc outside
    issue(beat_of(REQ_READ,  SZ_WORD, 32'h0800_0003, 32'h0, 32'h0));          // cart wrap
    issue(beat_of(REQ_WRITE, SZ_WORD, 32'h0E00_0000, 32'h5555_5555, 32'h0));  // save region
    issue(beat_of(2'd3,      SZ_WORD, 32'h0200_0000, 32'h0, 32'h0));          // unused codes
    issue(beat_of(REQ_WRITE, 2'd3,    32'h0200_0000, 32'h0, 32'h0));
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) sent <= sent + 1;
      // a stalled beat holds; otherwise offer the next one or idle
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: response beat with none expected: got %h", $time, rsp);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.read_data !== want.read_data) begin
            errors++;
            $display("%0t: read_data expected %h got %h", $time, want.read_data, rsp.read_data);
          end
          if (rsp.fifo_push !== want.fifo_push) begin
            errors++;
            $display("%0t: fifo_push expected %0d got %0d", $time, want.fifo_push, rsp.fifo_push);
          end
          if (rsp.fifo_word !== want.fifo_word) begin
            errors++;
            $display("%0t: fifo_word expected %h got %h", $time, want.fifo_word, rsp.fifo_word);
          end
          if (rsp.fifo_a_clear !== want.fifo_a_clear) begin
            errors++;
            $display("%0t: fifo_a_clear expected %b got %b", $time, want.fifo_a_clear,
                     rsp.fifo_a_clear);
          end
          if (rsp.fifo_b_clear !== want.fifo_b_clear) begin
            errors++;
            $display("%0t: fifo_b_clear expected %b got %b", $time, want.fifo_b_clear,
                     rsp.fifo_b_clear);
          end
        end
      end
      // one long hold-off so the block backs up into its request side
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && sent >= 250) begin
        hold_left <= 400;
        hold_done <= 1'b1;
      end
      rsp_stall <= (hold_left > 1) || (!calm && $urandom_range(99) < 28);
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    boot_on = 1'b0;
    cart_cfg = '0;
    eeprom_on = 1'b0;
    bus_latch = '0;
    foreach (io_bytes[i]) io_bytes[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    setup_phase(1'b1, SIZE_W'(5), 1'b0);
    directed_items();
    repeat (180) random_item();

    setup_phase(1'b0, SIZE_W'(0), 1'b0);
    repeat (150) random_item();

    // largest size field saturates to the full rom
    setup_phase(1'b1, {SIZE_W{1'b1}}, 1'b1);
    repeat (150) random_item();

    setup_phase(1'b1, SIZE_W'(100), 1'b0);
    repeat (150) random_item();

    setup_phase(1'b0, SIZE_W'(CART_ROM_BYTES_DEF), 1'b1);
    repeat (150) random_item();

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/hmbd_pkg.sv
hw/rtl/hmbd_byte_ram.sv
hw/rtl/hmbd_mod_unit.sv
hw/rtl/handheld_memory_bus_decoder.sv
dv/handheld_memory_bus_decoder_test.sv
